@@ src/cda_pkg.sv @@
package cda_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int DAY_IN_W   = 6;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 16;
   localparam int AMOUNT_W   = 16;
   localparam int ACC_W      = 17;

   localparam logic [DAY_W-1:0]   RESET_DAY       = 5'd1;
   localparam logic [MONTH_W-1:0] RESET_MONTH     = 4'd1;
   localparam logic [YEAR_W-1:0]  RESET_YEAR      = 16'd2000;
   localparam logic [MONTH_W-1:0] FIRST_MONTH     = 4'd1;
   localparam logic [MONTH_W-1:0] LAST_MONTH      = 4'd12;
   localparam logic [DAY_W-1:0]   MONTHS_PER_YEAR = 5'd12;

   localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
   localparam logic [MONTH_W-1:0] APRIL     = 4'd4;
   localparam logic [MONTH_W-1:0] JUNE      = 4'd6;
   localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
   localparam logic [MONTH_W-1:0] NOVEMBER  = 4'd11;

   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

   // Multiplicative inverse of 25 modulo 2^16 and the largest product that
   // marks a multiple of 25.
   localparam logic [YEAR_W-1:0] INV_25      = 16'd23593;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SET    = 2'd0,
      REQ_DAYS   = 2'd1,
      REQ_MONTHS = 2'd2,
      REQ_YEARS  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SET_WAIT,
      S_SET_CLAMP,
      S_MONTH_STEP,
      S_DAY_WAIT,
      S_DAY_STEP,
      S_YEAR_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [ACC_W-1:0] diff;
      logic             gt;
   } alu_res_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      if (month == FEBRUARY) begin
         len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      end else if (month == APRIL || month == JUNE || month == SEPTEMBER ||
                   month == NOVEMBER) begin
         len = DAYS_SHORT;
      end else begin
         len = DAYS_LONG;
      end
      return len;
   endfunction

endpackage

@@ src/cda_if.sv @@
interface cda_req_if import cda_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [DAY_IN_W-1:0]   day_in;
   logic [MONTH_W-1:0]    month_in;
   logic [YEAR_W-1:0]     year_in;
   logic [AMOUNT_W-1:0]   amount;

   modport source (output valid, req_type, day_in, month_in, year_in, amount,
                   input ready);
   modport sink (input valid, req_type, day_in, month_in, year_in, amount,
                 output ready);
endinterface

interface cda_rsp_if import cda_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   day_out;
   logic [MONTH_W-1:0] month_out;
   logic [YEAR_W-1:0]  year_out;
   logic               leap_out;

   modport source (output valid, day_out, month_out, year_out, leap_out,
                   input ready);
   modport sink (input valid, day_out, month_out, year_out, leap_out,
                 output ready);
endinterface

@@ src/calendar_date_adder_top.sv @@
// Holds one Gregorian date and applies one request at a time, returning one
// result per request. Set date passes through a wait state and a clamp step
// and add years through a wait state before the finishing step. Add days
// repeats a wait state and a step for every month that is rolled over. Add
// months repeats a step for every year boundary that is crossed and then
// settles the day, rolling it into the following month when it overflows.
// The sequencer drives a single subtract-and-compare unit and lets the
// registered leap-year unit settle in a wait state before a new year is read. The block
// takes a new request whenever the sequencer is idle, even while the previous
// result still waits in the output register.
module calendar_date_adder_top import cda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cda_req_if.sink   req_port,
   cda_rsp_if.source rsp_port
);

   state_type          state_ff, state_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DAY_W-1:0]   cur_day_ff, cur_day_in;
   logic [MONTH_W-1:0] cur_month_ff, cur_month_in;
   logic [YEAR_W-1:0]  cur_year_ff, cur_year_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]   rsp_day_ff;
   logic [MONTH_W-1:0] rsp_month_ff;
   logic [YEAR_W-1:0]  rsp_year_ff;
   logic               rsp_leap_ff;

   logic               leap;
   logic [DAY_W-1:0]   len;
   logic [DAY_W-1:0]   alu_sub;
   alu_res_type        alu_res;
   logic               load_rsp;
   logic               req_xfer;

   cda_leap u_leap (
      .clock (clock),
      .year  (cur_year_ff),
      .leap  (leap)
   );

   cda_alu u_alu (
      .acc (acc_ff),
      .sub (alu_sub),
      .res (alu_res)
   );

   assign len      = month_len(cur_month_ff, leap);
   assign req_xfer = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= RESET_DAY;
         cur_month_ff <= RESET_MONTH;
         cur_year_ff  <= RESET_YEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (load_rsp) begin
         rsp_day_ff   <= cur_day_ff;
         rsp_month_ff <= cur_month_ff;
         rsp_year_ff  <= cur_year_ff;
         rsp_leap_ff  <= leap;
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      alu_sub      = len;
      load_rsp     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               case (req_kind_type'(req_port.req_type))
                  REQ_SET: begin
                     cur_year_in = req_port.year_in;
                     if (req_port.month_in > LAST_MONTH) begin
                        cur_month_in = LAST_MONTH;
                     end else if (req_port.month_in < FIRST_MONTH) begin
                        cur_month_in = FIRST_MONTH;
                     end else begin
                        cur_month_in = req_port.month_in;
                     end
                     acc_in   = ACC_W'(req_port.day_in);
                     state_in = S_SET_WAIT;
                  end
                  REQ_DAYS: begin
                     acc_in   = ACC_W'(cur_day_ff) + ACC_W'(req_port.amount);
                     state_in = S_DAY_WAIT;
                  end
                  REQ_MONTHS: begin
                     acc_in   = ACC_W'(cur_month_ff) + ACC_W'(req_port.amount);
                     state_in = S_MONTH_STEP;
                  end
                  REQ_YEARS: begin
                     cur_year_in = cur_year_ff + req_port.amount;
                     state_in    = S_YEAR_WAIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SET_WAIT: begin
            state_in = S_SET_CLAMP;
         end
         S_SET_CLAMP: begin
            if (alu_res.gt) begin
               cur_day_in = len;
            end else if (acc_ff == '0) begin
               cur_day_in = RESET_DAY;
            end else begin
               cur_day_in = acc_ff[DAY_W-1:0];
            end
            state_in = S_FINISH;
         end
         S_MONTH_STEP: begin
            alu_sub = MONTHS_PER_YEAR;
            if (alu_res.gt) begin
               acc_in      = alu_res.diff;
               cur_year_in = cur_year_ff + 16'd1;
            end else begin
               cur_month_in = acc_ff[MONTH_W-1:0];
               acc_in       = ACC_W'(cur_day_ff);
               state_in     = S_DAY_WAIT;
            end
         end
         S_DAY_WAIT: begin
            state_in = S_DAY_STEP;
         end
         S_DAY_STEP: begin
            if (alu_res.gt) begin
               acc_in = alu_res.diff;
               if (cur_month_ff == LAST_MONTH) begin
                  cur_month_in = FIRST_MONTH;
                  cur_year_in  = cur_year_ff + 16'd1;
               end else begin
                  cur_month_in = cur_month_ff + 4'd1;
               end
               state_in = S_DAY_WAIT;
            end else begin
               cur_day_in = acc_ff[DAY_W-1:0];
               state_in   = S_FINISH;
            end
         end
         S_YEAR_WAIT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_port.ready     = state_ff == S_IDLE;
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.day_out   = rsp_day_ff;
   assign rsp_port.month_out = rsp_month_ff;
   assign rsp_port.year_out  = rsp_year_ff;
   assign rsp_port.leap_out  = rsp_leap_ff;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cur_month_ff >= FIRST_MONTH && cur_month_ff <= LAST_MONTH)
      else $error("Held month is outside 1 to 12.");

   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> cur_day_ff != '0)
      else $error("Held day is zero.");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != S_IDLE)
      else $error("Sequencer stayed idle after a request transfer.");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("Result raised outside the finishing step.");

endmodule

@@ src/cda_alu.sv @@
module cda_alu import cda_pkg::*; (
   input  logic [ACC_W-1:0] acc,
   input  logic [DAY_W-1:0] sub,
   output alu_res_type      res
);

   logic [ACC_W-1:0] sub_ext;

   assign sub_ext  = ACC_W'(sub);
   assign res.diff = acc - sub_ext;
   assign res.gt   = acc > sub_ext;

endmodule

@@ src/cda_leap.sv @@
module cda_leap import cda_pkg::*; (
   input  logic              clock,
   input  logic [YEAR_W-1:0] year,
   output logic              leap
);

   logic [YEAR_W-1:0] prod;
   logic              div25;
   logic              leap_ff;
   logic              leap_in;

   // A year is a multiple of 25 exactly when its product with the inverse of
   // 25 stays at or below the limit; the factors of 4 and 16 come from the
   // low bits.
   assign prod    = year * INV_25;
   assign div25   = prod <= DIV25_LIMIT;
   assign leap_in = (year[1:0] == 2'd0) && (!div25 || year[3:0] == 4'd0);

   always_ff @(posedge clock) begin
      leap_ff <= leap_in;
   end

   assign leap = leap_ff;

endmodule

@@ test/calendar_date_adder_top_test.sv @@
module calendar_date_adder_top_test;
   import cda_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int WATCHDOG_TIME = 60_000_000;
   localparam int YEAR_SPAN     = 1 << YEAR_W;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct {
      req_kind_type          kind;
      logic [DAY_IN_W-1:0]   day_in;
      logic [MONTH_W-1:0]    month_in;
      logic [YEAR_W-1:0]     year_in;
      logic [AMOUNT_W-1:0]   amount;
      bit                    drain_first;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cda_req_if req_if ();
   cda_rsp_if rsp_if ();

   calendar_date_adder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   request_type request_queue [$];
   date_type    pending_dates [$];
   date_type    calendar = '{RESET_DAY, RESET_MONTH, RESET_YEAR};

   logic req_taken      = 1'b0;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_total     = 0;
   int   hold_served    = 0;
   int   queued_count   = 0;
   int   accepted_count = 0;
   int   result_count   = 0;
   int   error_count    = 0;
   int   kind_count [4] = '{0, 0, 0, 0};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(WATCHDOG_TIME);
      $display("Timed out with %0d results still outstanding.", pending_dates.size());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit leap_year(input int year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   function automatic int month_days(input int month, input int year);
      if (month == FEBRUARY) begin
         return leap_year(year) ? 29 : 28;
      end
      if (month == APRIL || month == JUNE || month == SEPTEMBER || month == NOVEMBER) begin
         return 30;
      end
      return 31;
   endfunction

   function automatic date_type next_date(input date_type cur, input request_type r);
      int       day;
      int       month;
      int       year;
      int       len;
      date_type res;
      day = cur.day;
      month = cur.month;
      year = cur.year;
      case (r.kind)
         REQ_SET: begin
            year = r.year_in;
            month = (r.month_in > LAST_MONTH) ? LAST_MONTH :
                    (r.month_in < FIRST_MONTH) ? FIRST_MONTH : r.month_in;
            len = month_days(month, year);
            day = (r.day_in > len) ? len : (r.day_in < 1) ? 1 : r.day_in;
         end
         REQ_DAYS: begin
            day = day + r.amount;
         end
         REQ_MONTHS: begin
            month = month + r.amount;
            year = (year + (month - 1) / MONTHS_PER_YEAR) % YEAR_SPAN;
            month = (month - 1) % MONTHS_PER_YEAR + 1;
         end
         default: begin
            year = (year + r.amount) % YEAR_SPAN;
         end
      endcase
      if (r.kind == REQ_DAYS || r.kind == REQ_MONTHS) begin
         while (day > month_days(month, year)) begin
            day = day - month_days(month, year);
            month = month + 1;
            if (month > LAST_MONTH) begin
               month = FIRST_MONTH;
               year = (year + 1) % YEAR_SPAN;
            end
         end
      end
      res.day = day[DAY_W-1:0];
      res.month = month[MONTH_W-1:0];
      res.year = year[YEAR_W-1:0];
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : track_transfers
      request_type r;
      date_type    want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (reset) begin
         calendar = '{RESET_DAY, RESET_MONTH, RESET_YEAR};
      end else begin
         if (req_if.valid && req_if.ready) begin
            r.kind = req_kind_type'(req_if.req_type);
            r.day_in = req_if.day_in;
            r.month_in = req_if.month_in;
            r.year_in = req_if.year_in;
            r.amount = req_if.amount;
            calendar = next_date(calendar, r);
            pending_dates.push_back(calendar);
            kind_count[r.kind]++;
            accepted_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (pending_dates.size() == 0) begin
               report_error($sformatf("result %0d arrived with no request outstanding",
                                      result_count));
            end else begin
               want = pending_dates.pop_front();
               if (rsp_if.day_out !== want.day) begin
                  report_error($sformatf("result %0d: day_out %0d, expected %0d",
                                         result_count, rsp_if.day_out, want.day));
               end
               if (rsp_if.month_out !== want.month) begin
                  report_error($sformatf("result %0d: month_out %0d, expected %0d",
                                         result_count, rsp_if.month_out, want.month));
               end
               if (rsp_if.year_out !== want.year) begin
                  report_error($sformatf("result %0d: year_out %0d, expected %0d",
                                         result_count, rsp_if.year_out, want.year));
               end
               if (rsp_if.leap_out !== leap_year(want.year)) begin
                  report_error($sformatf("result %0d: leap_out %b, expected %b",
                                         result_count, rsp_if.leap_out,
                                         leap_year(want.year)));
               end
            end
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = REQ_SET;
      req_if.day_in = '0;
      req_if.month_in = '0;
      req_if.year_in = '0;
      req_if.amount = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin : drive_requests
      request_type item;
      logic        offer;
      offer = req_if.valid && !req_taken;
      if (reset) begin
         offer = 1'b0;
      end else if (!offer && request_queue.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct &&
                   (!request_queue[0].drain_first || pending_dates.size() == 0)) begin
         item = request_queue.pop_front();
         offer = 1'b1;
         req_if.req_type <= item.kind;
         req_if.day_in <= item.day_in;
         req_if.month_in <= item.month_in;
         req_if.year_in <= item.year_in;
         req_if.amount <= item.amount;
      end
      req_if.valid <= offer;
   end

   always @(negedge clock) begin : accept_results
      logic take;
      if (reset) begin
         take = 1'b0;
      end else if (hold_served < hold_total) begin
         take = 1'b0;
         hold_served++;
      end else begin
         take = $urandom_range(99) >= recv_stall_pct;
      end
      rsp_if.ready <= take;
   end

   task automatic queue_request(input req_kind_type kind, input int day, input int month,
                                input int year, input int amount, input bit drain_first);
      request_type item;
      item.kind = kind;
      item.day_in = day[DAY_IN_W-1:0];
      item.month_in = month[MONTH_W-1:0];
      item.year_in = year[YEAR_W-1:0];
      item.amount = amount[AMOUNT_W-1:0];
      item.drain_first = drain_first;
      request_queue.push_back(item);
      queued_count++;
   endtask

   function automatic int pick_year();
      case ($urandom_range(3))
         0: return $urandom_range(YEAR_SPAN - 1);
         1: return $urandom_range(163) * 400;
         2: return $urandom_range(16383) * 4;
         default: return $urandom_range(2100, 1900);
      endcase
   endfunction

   function automatic int pick_amount(input req_kind_type kind);
      int spread;
      spread = $urandom_range(99);
      if (kind == REQ_SET || kind == REQ_YEARS || spread >= 92) begin
         return $urandom_range(YEAR_SPAN - 1);
      end
      return (spread < 80) ? $urandom_range(400) : $urandom_range(5000);
   endfunction

   task automatic queue_random_requests(input int count);
      int           made;
      req_kind_type kind;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 30) begin
            // Land on 29 February, move the year, then let an add request settle the day.
            queue_request(REQ_SET, $urandom_range(63, 29), FEBRUARY,
                          $urandom_range(16383) * 4, pick_amount(REQ_SET), 1'b0);
            queue_request(REQ_YEARS, $urandom_range(63), $urandom_range(15), pick_year(),
                          pick_amount(REQ_YEARS), 1'b0);
            kind = $urandom_range(1) ? REQ_DAYS : REQ_MONTHS;
            queue_request(kind, $urandom_range(63), $urandom_range(15), pick_year(),
                          $urandom_range(3), 1'b0);
            made += 3;
         end else begin
            kind = req_kind_type'($urandom_range(3));
            queue_request(kind, $urandom_range(63), $urandom_range(15), pick_year(),
                          pick_amount(kind), 1'b0);
            made++;
         end
      end
   endtask

   task automatic wait_until_drained();
      while (accepted_count != queued_count || pending_dates.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_request(REQ_SET, 0, 0, 0, 65535, 1'b0);
      queue_request(REQ_SET, 63, 15, 65535, 0, 1'b0);
      queue_request(REQ_DAYS, 63, 15, 65535, 1, 1'b0);
      queue_request(REQ_SET, 29, FEBRUARY, 1900, 0, 1'b0);
      queue_request(REQ_DAYS, 0, 0, 0, 1, 1'b0);
      queue_request(REQ_SET, 29, FEBRUARY, 2000, 0, 1'b0);
      queue_request(REQ_YEARS, 0, 0, 0, 1, 1'b0);
      queue_request(REQ_DAYS, 0, 0, 0, 0, 1'b0);
      queue_request(REQ_SET, 29, FEBRUARY, 2004, 0, 1'b0);
      queue_request(REQ_YEARS, 0, 0, 0, 96, 1'b0);
      queue_request(REQ_MONTHS, 0, 0, 0, 0, 1'b0);
      queue_request(REQ_SET, 31, 1, 2023, 0, 1'b1);
      queue_request(REQ_MONTHS, 0, 0, 0, 1, 1'b0);
      queue_request(REQ_SET, 31, APRIL, 2023, 0, 1'b0);
      queue_request(REQ_MONTHS, 63, 15, 65535, 65535, 1'b0);
      queue_request(REQ_DAYS, 63, 15, 65535, 65535, 1'b0);
      queue_request(REQ_YEARS, 63, 15, 65535, 65535, 1'b0);
      queue_request(REQ_SET, 31, 12, 65535, 0, 1'b0);
      queue_request(REQ_MONTHS, 0, 0, 0, 12, 1'b0);
      queue_request(REQ_DAYS, 0, 0, 0, 365, 1'b0);
      queue_request(REQ_SET, 30, FEBRUARY, 2024, 0, 1'b0);
      queue_request(REQ_SET, 15, 13, 2024, 0, 1'b0);
      wait_until_drained();

      queue_random_requests(18);
      wait_until_drained();

      send_idle_pct = 72;
      queue_random_requests(18);
      wait_until_drained();

      send_idle_pct = 0;
      recv_stall_pct = 72;
      queue_random_requests(18);
      wait_until_drained();

      send_idle_pct = 16;
      recv_stall_pct = 16;
      queue_random_requests(18);
      wait_until_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_total = hold_total + HOLD_CYCLES;
      queue_random_requests(8);
      queue_request(REQ_DAYS, 0, 0, 0, 59, 1'b1);
      queue_random_requests(4);
      wait_until_drained();

      repeat (40) @(posedge clock);
      $display("Checked %0d results: %0d set date, %0d add days, %0d add months, %0d add years.",
               result_count, kind_count[REQ_SET], kind_count[REQ_DAYS],
               kind_count[REQ_MONTHS], kind_count[REQ_YEARS]);
      $display("Traffic ran steady, with sender gaps, result stalls, both, and a %0d-cycle %s",
               HOLD_CYCLES, "result hold-off followed by a drain pause.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
